FILE: src/drs_pkg.sv
// Shared constants, types and helpers for the disk request scheduler.
package drs_pkg;

    localparam int QUEUE_SLOTS   = 16;
    localparam int NUM_TYPES     = 4;
    localparam int NUM_PRIO_REGS = 4;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int TYPE_W   = 2;
    localparam int POS_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int PRIO_W   = 4;

    localparam int IDX_W     = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CNT_INT_W = $clog2(QUEUE_SLOTS + 1);
    localparam int CMP_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;

    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_W  = $clog2(NUM_PRIO_REGS);
    localparam int APB_ADDR_W = REG_SEL_W + 2;

    localparam logic [PRIO_W-1:0] WORST_PRIO = '1;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SELECT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OCCUPIED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

    typedef logic [NUM_PRIO_REGS-1:0][PRIO_W-1:0] prio_arr_t;

    // Operation word marching down the cell row
    typedef struct packed {
        logic                  active;
        logic [FUNC_W-1:0]     func;
        logic [SLOT_W-1:0]     slot;
        logic [TYPE_W-1:0]     req_type;
        logic [POS_W-1:0]      target_pos;
        logic [POS_W-1:0]      head_pos;
        logic [STATUS_W-1:0]   status;
        logic                  found;
        logic [IDX_W-1:0]      best_slot;
        logic [PRIO_W-1:0]     best_pri;
        logic [POS_W-1:0]      best_dist;
        logic [POS_W-1:0]      best_pos;
        logic [CNT_INT_W-1:0]  count;
    } token_t;

    function automatic logic [PRIO_W-1:0] prio_of(prio_arr_t prio, logic [TYPE_W-1:0] t);
        logic [PRIO_W-1:0] p;
        if (int'(t) >= NUM_TYPES || int'(t) >= NUM_PRIO_REGS)
        begin
            p = WORST_PRIO;
        end
        else
        begin
            p = prio[t];
        end
        return p;
    endfunction

endpackage

FILE: src/drs_req_if.sv
// Request channel: valid/ready plus one request word.
interface drs_req_if;
    logic                          valid;
    logic                          ready;
    logic [drs_pkg::FUNC_W-1:0]    func;
    logic [drs_pkg::SLOT_W-1:0]    slot;
    logic [drs_pkg::TYPE_W-1:0]    req_type;
    logic [drs_pkg::POS_W-1:0]     target_pos;
    logic [drs_pkg::POS_W-1:0]     head_pos;

    modport source (output valid, func, slot, req_type, target_pos, head_pos, input ready);
    modport sink   (input valid, func, slot, req_type, target_pos, head_pos, output ready);
endinterface

FILE: src/drs_rsp_if.sv
// Response channel: valid/ready plus one result word.
interface drs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [drs_pkg::STATUS_W-1:0]  status;
    logic [drs_pkg::SLOT_W-1:0]    picked_slot;
    logic [drs_pkg::POS_W-1:0]     picked_pos;
    logic [drs_pkg::COUNT_W-1:0]   pending_count;

    modport source (output valid, status, picked_slot, picked_pos, pending_count, input ready);
    modport sink   (input valid, status, picked_slot, picked_pos, pending_count, output ready);
endinterface

FILE: src/disk_request_scheduler.sv
// Top level: priority one-way-scan disk request scheduler built as a row of entry cells.
//
//  channel | dir | handshake        | word
//  --------+-----+------------------+------------------------------------------------
//  req     | in  | valid/ready      | func, slot, req_type, target_pos, head_pos
//  rsp     | out | valid/ready      | status, picked_slot, picked_pos, pending_count
//  apb     | in  | psel/penable     | prio_type0..3 at 0x0, 0x4, 0x8, 0xC
//
//  A word walks the row one cell per cycle, through each cell's register in turn,
//  then through the result register. One word is in flight at a time.
//  A finished result waits in the output register while the next word is taken.
//  Reset clears every entry valid bit and loads the priorities with 0, 1, 2, 3.
module disk_request_scheduler (
    input  logic                            clk,
    input  logic                            rst_n,
    drs_req_if.sink                         req,
    drs_rsp_if.source                       rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [drs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [drs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [drs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    drs_pkg::prio_arr_t                  prio_reg;
    logic [drs_pkg::REG_SEL_W-1:0]       reg_sel;
    logic                                cfg_wr;

    logic                                busy_reg;
    logic                                res_valid_reg;
    logic [drs_pkg::STATUS_W-1:0]        res_status_reg;
    logic [drs_pkg::SLOT_W-1:0]          res_slot_reg;
    logic [drs_pkg::POS_W-1:0]           res_pos_reg;
    logic [drs_pkg::COUNT_W-1:0]         res_count_reg;

    logic                                rsp_valid_reg;
    logic [drs_pkg::STATUS_W-1:0]        rsp_status_reg;
    logic [drs_pkg::SLOT_W-1:0]          rsp_slot_reg;
    logic [drs_pkg::POS_W-1:0]           rsp_pos_reg;
    logic [drs_pkg::COUNT_W-1:0]         rsp_count_reg;

    logic                                req_fire;
    logic                                res_move;
    drs_pkg::token_t                     tok_chain [drs_pkg::QUEUE_SLOTS+1];
    drs_pkg::token_t                     tok_head;
    drs_pkg::token_t                     tok_end;
    logic                                pick;
    logic [drs_pkg::QUEUE_SLOTS-1:0]     clr_vec;
    logic [drs_pkg::QUEUE_SLOTS-1:0]     valid_vec;
    logic [drs_pkg::QUEUE_SLOTS-1:0]     act_vec;
    logic [drs_pkg::CNT_INT_W-1:0]       cnt_after;
    logic [drs_pkg::COUNT_W-1:0]         cnt_sat;
    logic [drs_pkg::STATUS_W-1:0]        init_status;

    // configuration port
    assign reg_sel = paddr[drs_pkg::APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = drs_pkg::APB_DATA_W'(prio_reg[reg_sel]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < drs_pkg::NUM_PRIO_REGS; i++)
            begin
                prio_reg[i] <= drs_pkg::PRIO_W'(i);
            end
        end
        else if (cfg_wr)
        begin
            prio_reg[reg_sel] <= pwdata[drs_pkg::PRIO_W-1:0];
        end
    end

    // word entry
    assign req_fire  = req.valid && req.ready;
    assign req.ready = !busy_reg;

    always_comb
    begin
        unique case (req.func)
            drs_pkg::FUNC_INSERT: init_status = drs_pkg::ST_OCCUPIED;
            drs_pkg::FUNC_REMOVE: init_status = drs_pkg::ST_EMPTY;
            drs_pkg::FUNC_SELECT: init_status = drs_pkg::ST_NONE;
            default:              init_status = drs_pkg::ST_OK;
        endcase
    end

    always_comb
    begin
        tok_head            = '0;
        tok_head.active     = req_fire;
        tok_head.func       = req.func;
        tok_head.slot       = req.slot;
        tok_head.req_type   = req.req_type;
        tok_head.target_pos = req.target_pos;
        tok_head.head_pos   = req.head_pos;
        tok_head.status     = init_status;
    end

    assign tok_chain[0] = tok_head;

    genvar g;
    generate
        for (g = 0; g < drs_pkg::QUEUE_SLOTS; g++)
        begin : g_cell
            drs_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (drs_pkg::IDX_W'(g)),
                .prio    (prio_reg),
                .tok_in  (tok_chain[g]),
                .clr     (clr_vec[g]),
                .tok_out (tok_chain[g+1]),
                .valid   (valid_vec[g])
            );
            assign clr_vec[g] = pick && (tok_end.best_slot == drs_pkg::IDX_W'(g));
            assign act_vec[g] = tok_chain[g+1].active;
        end
    endgenerate

    // row exit
    assign tok_end   = tok_chain[drs_pkg::QUEUE_SLOTS];
    assign pick      = tok_end.active && (tok_end.func == drs_pkg::FUNC_SELECT) && tok_end.found;
    assign cnt_after = tok_end.count - drs_pkg::CNT_INT_W'(pick);
    assign cnt_sat   = (int'(cnt_after) > drs_pkg::COUNT_MAX)
                     ? drs_pkg::COUNT_W'(drs_pkg::COUNT_MAX) : drs_pkg::COUNT_W'(cnt_after);
    assign res_move  = res_valid_reg && (!rsp_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                busy_reg <= 1'b1;
            end
            else if (res_move)
            begin
                busy_reg <= 1'b0;
            end

            if (tok_end.active)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_move)
            begin
                res_valid_reg <= 1'b0;
            end

            if (res_move)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_end.active)
        begin
            res_status_reg <= pick ? drs_pkg::ST_OK : tok_end.status;
            res_slot_reg   <= pick ? drs_pkg::SLOT_W'(tok_end.best_slot) : '0;
            res_pos_reg    <= pick ? tok_end.best_pos : '0;
            res_count_reg  <= cnt_sat;
        end
        if (res_move)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_slot_reg   <= res_slot_reg;
            rsp_pos_reg    <= res_pos_reg;
            rsp_count_reg  <= res_count_reg;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.picked_slot   = rsp_slot_reg;
    assign rsp.picked_pos    = rsp_pos_reg;
    assign rsp.pending_count = rsp_count_reg;

    // a word leaves the row only while its slot is still held
    a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok_end.active |-> (busy_reg && !res_valid_reg))
        else $error("word left the cell row with no item in flight");

    // never more than one word in the row
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(act_vec) <= 1)
        else $error("more than one word in the cell row");

    // reported count matches the table once the winner is cleared
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        tok_end.active |=> (int'(res_count_reg) == $countones(valid_vec)))
        else $error("pending count disagrees with the table");

endmodule

FILE: src/drs_cell.sv
// One table entry: applies the passing operation word to its own slot.
module drs_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [drs_pkg::IDX_W-1:0]  idx,
    input  drs_pkg::prio_arr_t         prio,
    input  drs_pkg::token_t            tok_in,
    input  logic                       clr,
    output drs_pkg::token_t            tok_out,
    output logic                       valid
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [drs_pkg::TYPE_W-1:0]    type_reg;
    logic [drs_pkg::TYPE_W-1:0]    type_next;
    logic [drs_pkg::POS_W-1:0]     pos_reg;
    logic [drs_pkg::POS_W-1:0]     pos_next;
    drs_pkg::token_t               tok_reg;
    drs_pkg::token_t               tok_next;

    logic                          hit;
    logic [drs_pkg::PRIO_W-1:0]    pri;
    logic [drs_pkg::POS_W-1:0]     span;
    logic                          better;

    assign hit  = (drs_pkg::CMP_W'(tok_in.slot) == drs_pkg::CMP_W'(idx));
    assign pri  = drs_pkg::prio_of(prio, type_reg);
    assign span = pos_reg - tok_in.head_pos;
    assign better = !tok_in.found || (pri < tok_in.best_pri)
                  || ((pri == tok_in.best_pri) && (span < tok_in.best_dist));

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        type_next  = type_reg;
        pos_next   = pos_reg;
        if (tok_in.active)
        begin
            unique case (tok_in.func)
                drs_pkg::FUNC_INSERT:
                begin
                    if (hit && !valid_reg)
                    begin
                        valid_next      = 1'b1;
                        type_next       = tok_in.req_type;
                        pos_next        = tok_in.target_pos;
                        tok_next.status = drs_pkg::ST_OK;
                    end
                end
                drs_pkg::FUNC_REMOVE:
                begin
                    if (hit && valid_reg)
                    begin
                        valid_next      = 1'b0;
                        tok_next.status = drs_pkg::ST_OK;
                    end
                end
                drs_pkg::FUNC_SELECT:
                begin
                    if (valid_reg && better)
                    begin
                        tok_next.found     = 1'b1;
                        tok_next.best_slot = idx;
                        tok_next.best_pri  = pri;
                        tok_next.best_dist = span;
                        tok_next.best_pos  = pos_reg;
                    end
                end
                default:
                begin
                end
            endcase
            tok_next.count = tok_in.count + drs_pkg::CNT_INT_W'(valid_next);
        end
        // select winner removal, issued after the word leaves the row
        if (clr)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        pos_reg  <= pos_next;
    end

    assign tok_out = tok_reg;
    assign valid   = valid_reg;

endmodule

FILE: sim/drs_checker.sv
// Scoreboard for the disk request scheduler: predicts each result word and compares it.
module drs_checker
    import drs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    drs_req_if                     req,
    drs_rsp_if                     rsp,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   pready,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output int unsigned            words_waiting,
    output int unsigned            words_checked,
    output int unsigned            mismatches
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [POS_W-1:0]    pos;
        logic [COUNT_W-1:0]  count;
    } sched_word_t;

    logic              table_valid [QUEUE_SLOTS];
    logic [TYPE_W-1:0] table_type  [QUEUE_SLOTS];
    logic [POS_W-1:0]  table_pos   [QUEUE_SLOTS];
    logic [PRIO_W-1:0] type_prio   [NUM_PRIO_REGS];

    sched_word_t expected_words[$];
    sched_word_t got_word;
    sched_word_t want_word;

    function automatic logic [PRIO_W-1:0] rank(logic [TYPE_W-1:0] t);
        if (int'(t) < NUM_TYPES && int'(t) < NUM_PRIO_REGS)
        begin
            return type_prio[t];
        end
        return '1;
    endfunction

    function automatic logic [COUNT_W-1:0] occupancy();
        int n;
        n = 0;
        for (int i = 0; i < QUEUE_SLOTS; i++)
        begin
            if (table_valid[i])
            begin
                n++;
            end
        end
        if (n > COUNT_MAX)
        begin
            n = COUNT_MAX;
        end
        return COUNT_W'(n);
    endfunction

    // Applies one request word to the shadow table and returns the result it should give.
    function automatic sched_word_t schedule(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
                                             logic [TYPE_W-1:0] rtype, logic [POS_W-1:0] tpos,
                                             logic [POS_W-1:0] head);
        sched_word_t       r;
        logic              found;
        int                best;
        int                s;
        logic [PRIO_W-1:0] best_pri;
        logic [PRIO_W-1:0] p;
        logic [POS_W-1:0]  best_dist;
        logic [POS_W-1:0]  d;
        r = '0;
        r.status = ST_OK;
        s = int'(slot);
        case (func)
            FUNC_INSERT:
            begin
                if (s >= QUEUE_SLOTS || table_valid[s])
                begin
                    r.status = ST_OCCUPIED;
                end
                else
                begin
                    table_valid[s] = 1'b1;
                    table_type[s]  = rtype;
                    table_pos[s]   = tpos;
                end
            end
            FUNC_REMOVE:
            begin
                if (s >= QUEUE_SLOTS || !table_valid[s])
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    table_valid[s] = 1'b0;
                    table_type[s]  = '0;
                    table_pos[s]   = '0;
                end
            end
            FUNC_SELECT:
            begin
                found     = 1'b0;
                best      = 0;
                best_pri  = '0;
                best_dist = '0;
                for (int i = 0; i < QUEUE_SLOTS; i++)
                begin
                    if (table_valid[i])
                    begin
                        p = rank(table_type[i]);
                        d = table_pos[i] - head;
                        if (!found || p < best_pri || (p == best_pri && d < best_dist))
                        begin
                            found     = 1'b1;
                            best      = i;
                            best_pri  = p;
                            best_dist = d;
                        end
                    end
                end
                if (!found)
                begin
                    r.status = ST_NONE;
                end
                else
                begin
                    r.slot = SLOT_W'(best);
                    r.pos  = table_pos[best];
                    table_valid[best] = 1'b0;
                    table_type[best]  = '0;
                    table_pos[best]   = '0;
                end
            end
            default:
            begin
            end
        endcase
        r.count = occupancy();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                table_valid[i] = 1'b0;
                table_type[i]  = '0;
                table_pos[i]   = '0;
            end
            for (int k = 0; k < NUM_PRIO_REGS; k++)
            begin
                type_prio[k] = PRIO_W'(k);
            end
            expected_words.delete();
            words_waiting = 0;
            words_checked = 0;
            mismatches    = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got_word = {rsp.status, rsp.picked_slot, rsp.picked_pos, rsp.pending_count};
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result word: status %0d slot %0d pos %h count %0d",
                                 got_word.status, got_word.slot, got_word.pos, got_word.count);
                    end
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    words_checked++;
                    if (got_word.status !== want_word.status || got_word.slot !== want_word.slot
                        || got_word.pos !== want_word.pos || got_word.count !== want_word.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result word %0d: expected status %0d slot %0d pos %h count %0d",
                                     words_checked, want_word.status, want_word.slot,
                                     want_word.pos, want_word.count);
                            $display("result word %0d:      got status %0d slot %0d pos %h count %0d",
                                     words_checked, got_word.status, got_word.slot,
                                     got_word.pos, got_word.count);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_words.push_back(schedule(req.func, req.slot, req.req_type,
                                                  req.target_pos, req.head_pos));
            end
            if (psel && penable && pwrite && pready
                && int'(paddr[APB_ADDR_W-1:2]) < NUM_PRIO_REGS)
            begin
                type_prio[paddr[APB_ADDR_W-1:2]] = pwdata[PRIO_W-1:0];
            end
            words_waiting = expected_words.size();
        end
    end

endmodule

FILE: sim/testbench.sv
// Testbench top for the disk request scheduler: stimulus, register setup, watchdog and verdict.
module testbench;
    import drs_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_IDLE = 2'd3;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_WORDS = 100;
    localparam int NUM_PHASES  = 6;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic                  pready;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;

    int unsigned words_waiting;
    int unsigned words_checked;
    int unsigned mismatches;
    int unsigned words_sent    = 0;
    int unsigned settings_used = 0;
    int unsigned idle_cycles   = 0;
    logic        no_idle       = 1'b0;
    logic [POS_W-1:0] pos_base = '0;
    prio_arr_t   prios;

    drs_req_if req_ch();
    drs_rsp_if rsp_ch();

    disk_request_scheduler i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    drs_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .words_waiting (words_waiting),
        .words_checked (words_checked),
        .mismatches    (mismatches)
    );

    always #5 clk = ~clk;

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // positions cluster around a base so distances tie and wrap
    function automatic logic [POS_W-1:0] pick_pos();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            return $urandom;
        end
        if (r < 70)
        begin
            return pos_base + POS_W'($urandom_range(0, 63)) - POS_W'(32);
        end
        if (r < 90)
        begin
            return pos_base + POS_W'(16 * $urandom_range(0, 3));
        end
        if (r < 95)
        begin
            return '0;
        end
        return '1;
    endfunction

    task automatic send_word(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
                             logic [TYPE_W-1:0] rtype, logic [POS_W-1:0] tpos,
                             logic [POS_W-1:0] head);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
        @(negedge clk);
        req_ch.valid      = 1'b1;
        req_ch.func       = func;
        req_ch.slot       = slot;
        req_ch.req_type   = rtype;
        req_ch.target_pos = tpos;
        req_ch.head_pos   = head;
        do @(posedge clk); while (!req_ch.ready);
        words_sent++;
    endtask

    task automatic random_word(int unsigned insert_pct);
        int unsigned       r;
        logic [FUNC_W-1:0] f;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
        begin
            f = FUNC_INSERT;
        end
        else if (r < insert_pct + 20)
        begin
            f = FUNC_REMOVE;
        end
        else if (r < 96)
        begin
            f = FUNC_SELECT;
        end
        else
        begin
            f = FUNC_IDLE;
        end
        send_word(f, SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1)),
                  TYPE_W'($urandom_range(0, (1 << TYPE_W) - 1)), pick_pos(), pick_pos());
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (words_waiting != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_priorities(prio_arr_t p);
        for (int k = 0; k < NUM_PRIO_REGS; k++)
        begin
            @(negedge clk);
            psel    = 1'b1;
            penable = 1'b0;
            pwrite  = 1'b1;
            paddr   = APB_ADDR_W'(k << 2);
            pwdata  = APB_DATA_W'(p[k]);
            @(negedge clk);
            penable = 1'b1;
            do @(posedge clk); while (!pready);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        settings_used++;
    endtask

    // receiver: random back-pressure
    initial
    begin
        int unsigned stall;
        rsp_ch.ready = 1'b0;
        forever
        begin
            stall = pick_gap();
            repeat (stall)
            begin
                @(negedge clk);
                rsp_ch.ready = 1'b0;
            end
            @(negedge clk);
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(0, 12)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_INSERT;
        req_ch.slot       = '0;
        req_ch.req_type   = '0;
        req_ch.target_pos = '0;
        req_ch.head_pos   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, occupied/empty slots, priority, distance and slot ties
        send_word(FUNC_SELECT, 4'd0, 2'd0, 32'h0, 32'h0);
        send_word(FUNC_REMOVE, 4'd0, 2'd0, 32'h0, 32'h0);
        send_word(FUNC_IDLE, 4'd15, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(FUNC_INSERT, 4'd0, 2'd0, 32'hFFFF_FFFF, 32'h0);
        send_word(FUNC_INSERT, 4'd0, 2'd3, 32'h0, 32'h0);
        send_word(FUNC_INSERT, 4'd15, 2'd3, 32'h0, 32'h0);
        send_word(FUNC_INSERT, 4'd5, 2'd1, 32'h8000_0000, 32'h0);
        send_word(FUNC_INSERT, 4'd10, 2'd2, 32'hAAAA_AAAA, 32'h0);
        send_word(FUNC_REMOVE, 4'd15, 2'd0, 32'h0, 32'h0);
        send_word(FUNC_REMOVE, 4'd15, 2'd0, 32'h0, 32'h0);
        send_word(FUNC_SELECT, 4'd0, 2'd0, 32'h0, 32'hFFFF_FFFF);
        send_word(FUNC_INSERT, 4'd3, 2'd1, 32'd100, 32'h0);
        send_word(FUNC_INSERT, 4'd7, 2'd1, 32'd100, 32'h0);
        send_word(FUNC_INSERT, 4'd2, 2'd1, 32'd50, 32'h0);
        send_word(FUNC_SELECT, 4'd0, 2'd0, 32'h0, 32'd60);
        send_word(FUNC_SELECT, 4'd0, 2'd0, 32'h0, 32'd60);
        send_word(FUNC_SELECT, 4'd0, 2'd0, 32'h0, 32'h5555_5555);
        send_word(FUNC_SELECT, 4'd0, 2'd0, 32'h0, 32'h0);
        send_word(FUNC_SELECT, 4'd0, 2'd0, 32'h0, 32'h0);
        send_word(FUNC_SELECT, 4'd0, 2'd0, 32'h0, 32'h0);
        send_word(FUNC_INSERT, 4'd9, 2'd2, 32'h5555_5555, 32'hAAAA_AAAA);
        send_word(FUNC_IDLE, 4'd6, 2'd1, 32'h1234_5678, 32'h8765_4321);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       prios = {4'd3, 4'd2, 4'd1, 4'd0};
                1:       prios = '0;
                2:       prios = '1;
                3:       prios = {4'd0, 4'd1, 4'd2, 4'd3};
                4:       prios = prio_arr_t'($urandom);
                default: prios = {4'd0, 4'd15, 4'd0, 4'd15};
            endcase
            no_idle  = (ph == 2);
            pos_base = $urandom;
            set_priorities(prios);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                random_word((n < PHASE_WORDS / 2) ? 60 : 35);
            end
            drain();
        end

        repeat (40) @(posedge clk);
        $display("summary: %0d request words under %0d priority settings, %0d results compared",
                 words_sent, settings_used, words_checked);
        $display("summary: empty and full table, slot conflicts, priority and distance ties");
        if (mismatches == 0 && words_waiting == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/drs_pkg.sv
src/drs_req_if.sv
src/drs_rsp_if.sv
src/drs_cell.sv
src/disk_request_scheduler.sv
sim/drs_checker.sv
sim/testbench.sv
